// ----- hdl/gdid_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gdid_pkg;

    // result kinds
    localparam logic [1:0] KIND_LITERAL  = 2'd0;
    localparam logic [1:0] KIND_COPY     = 2'd1;
    localparam logic [1:0] KIND_FINISHED = 2'd2;
    localparam logic [1:0] KIND_ERROR    = 2'd3;

    // error codes
    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_BASE_SIZE   = 4'd1;
    localparam logic [3:0] ERR_OPCODE_ZERO = 4'd2;
    localparam logic [3:0] ERR_ADD_TRUNC   = 4'd3;
    localparam logic [3:0] ERR_ADD_OVER    = 4'd4;
    localparam logic [3:0] ERR_COPY_TRUNC  = 4'd5;
    localparam logic [3:0] ERR_COPY_BEYOND = 4'd6;
    localparam logic [3:0] ERR_COPY_OVER   = 4'd7;
    localparam logic [3:0] ERR_UNDERFILL   = 4'd8;

    // largest copy length, also the meaning of a zero size
    localparam logic [16:0] COPY_MAX = 17'h10000;

    // result queue between parser and output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  literal_byte;
        logic [31:0] copy_offset;
        logic [16:0] copy_length;
        logic [31:0] target_size;
        logic [3:0]  error_code;
        logic        final_result;
    } t_result;

    // results caused by one item: first always present, second optional
    typedef struct packed {
        logic    two;
        t_result first;
        t_result second;
    } t_pair;

    typedef struct packed {
        logic  valid;
        t_pair pair;
    } t_push;

endpackage

`default_nettype wire

// ----- hdl/git_delta_instruction_decoder.sv -----
// Git pack delta decoder, one delta byte per input item. It accepts one byte every clock
// cycle and delivers one result item every cycle the output side is ready; a byte that
// causes two results (the last byte of a delta, closing a literal or copy command)
// occupies the output with both results in turn. The first result of a byte is written
// to the result queue and from there loaded into the output register: the parser
// classifies the byte and checks sizes in its cycle, a four-entry result queue decouples
// it from the output register, and input ready drops only while that queue is full.
// base_length and base_position are written through the plain register port and must
// only change while no delta is in progress.
`timescale 1ns / 1ps
`default_nettype none

module git_delta_instruction_decoder #(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_delta_byte,
    input  wire logic        i_end_of_delta,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_result_kind,
    output logic [7:0]       o_literal_byte,
    output logic [31:0]      o_copy_offset,
    output logic [16:0]      o_copy_length,
    output logic [31:0]      o_target_size,
    output logic [3:0]       o_error_code,
    output logic             o_final_result
);
    import gdid_pkg::*;

    t_push   push;
    t_pair   head;
    t_result result;
    logic    queue_full, queue_nonempty, pop;

    // byte parser and checks
    gdid_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_delta_byte  (i_delta_byte),
        .i_end_of_delta(i_end_of_delta),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_queue_full  (queue_full),
        .o_push        (push)
    );

    // result queue
    gdid_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_pop     (pop),
        .o_full    (queue_full),
        .o_nonempty(queue_nonempty),
        .o_head    (head)
    );

    // output stage
    gdid_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_nonempty(queue_nonempty),
        .i_head    (head),
        .o_pop     (pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_result  (result)
    );

    assign o_result_kind  = result.kind;
    assign o_literal_byte = result.literal_byte;
    assign o_copy_offset  = result.copy_offset;
    assign o_copy_length  = result.copy_length;
    assign o_target_size  = result.target_size;
    assign o_error_code   = result.error_code;
    assign o_final_result = result.final_result;

    // checks
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        queue_full |-> !push.valid)
        else $error("result queue written while full");

    a_final_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_final_result ==
            ((o_result_kind == KIND_FINISHED) || (o_result_kind == KIND_ERROR))))
        else $error("final flag does not match result kind");

    a_copy_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_result_kind == KIND_COPY)) |->
            ((o_copy_length != 17'd0) && (o_copy_length <= COPY_MAX)))
        else $error("copy length out of range");

endmodule

`default_nettype wire

// ----- hdl/gdid_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gdid_front #(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [7:0]      i_delta_byte,
    input  wire logic            i_end_of_delta,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_index,
    input  wire logic [31:0]     i_cfg_data,
    input  wire logic            i_queue_full,
    output gdid_pkg::t_push      o_push
);
    import gdid_pkg::*;

    localparam logic [2:0] PH_HDR_BASE = 3'd0;
    localparam logic [2:0] PH_HDR_TGT  = 3'd1;
    localparam logic [2:0] PH_OPCODE   = 3'd2;
    localparam logic [2:0] PH_ADD      = 3'd3;
    localparam logic [2:0] PH_ADD_SKIP = 3'd4;
    localparam logic [2:0] PH_COPY     = 3'd5;
    localparam logic [2:0] PH_DROP     = 3'd6;

    localparam logic CFG_BASE_LENGTH   = 1'b0;
    localparam logic CFG_BASE_POSITION = 1'b1;

    localparam logic [2:0] VARINT_GROUPS = 3'd5;

    logic [31:0]            r_base_length, r_base_position;
    logic [2:0]             r_phase, n_phase;
    logic [31:0]            r_acc, n_acc;
    logic [2:0]             r_grp, n_grp;
    logic [LENGTH_BITS-1:0] r_dts, n_dts;
    logic [LENGTH_BITS-1:0] r_tr, n_tr;
    logic [6:0]             r_abr, n_abr;
    logic [6:0]             r_flags, n_flags;
    logic [31:0]            r_off, n_off;
    logic [23:0]            r_len, n_len;

    logic                   accept;
    logic                   last;
    logic [31:0]            base_diff;
    logic [31:0]            payload;
    logic [31:0]            take_acc;
    logic [2:0]             take_grp;
    logic [LENGTH_BITS-1:0] hdr_size;
    logic [6:0]             abr_dec;
    logic [2:0]             low_bit;
    logic [4:0]             lane_base;
    logic [31:0]            gath_off;
    logic [23:0]            gath_len;
    logic [6:0]             gath_flags;
    logic [32:0]            tr_wide;

    logic                   emit_lit, emit_copy, fail_en, fin_en, restart, cd_en;
    logic [3:0]             fail_code;
    logic [31:0]            cd_off;
    logic [23:0]            cd_len;
    logic [23:0]            cd_size;
    logic [32:0]            cd_size_wide;
    logic                   cd_too_big, cd_beyond;
    t_result                prim, trail;

    function automatic t_result mk_err(input logic [3:0] code);
        t_result r;
        r              = '0;
        r.kind         = KIND_ERROR;
        r.error_code   = code;
        r.final_result = 1'b1;
        return r;
    endfunction

    function automatic t_result mk_fin(input logic [31:0] tsize);
        t_result r;
        r              = '0;
        r.kind         = KIND_FINISHED;
        r.target_size  = tsize;
        r.error_code   = ERR_NONE;
        r.final_result = 1'b1;
        return r;
    endfunction

    function automatic t_result mk_lit(input logic [7:0] b);
        t_result r;
        r              = '0;
        r.kind         = KIND_LITERAL;
        r.literal_byte = b;
        return r;
    endfunction

    function automatic t_result mk_copy(input logic [31:0] off, input logic [16:0] len);
        t_result r;
        r             = '0;
        r.kind        = KIND_COPY;
        r.copy_offset = off;
        r.copy_length = len;
        return r;
    endfunction

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && !i_queue_full;
    assign last    = i_end_of_delta;

    // size header accumulation, bits past 32 dropped
    assign payload = {25'd0, i_delta_byte[6:0]};
    always_comb begin
        case (r_grp)
            3'd0:    take_acc = r_acc | payload;
            3'd1:    take_acc = r_acc | (payload << 7);
            3'd2:    take_acc = r_acc | (payload << 14);
            3'd3:    take_acc = r_acc | (payload << 21);
            3'd4:    take_acc = r_acc | (payload << 28);
            default: take_acc = r_acc;
        endcase
    end
    assign take_grp  = (r_grp < VARINT_GROUPS) ? r_grp + 3'd1 : r_grp;
    assign hdr_size  = take_acc[LENGTH_BITS-1:0];
    assign base_diff = r_base_length - r_base_position;
    assign tr_wide   = 33'(r_tr);
    assign abr_dec   = r_abr - 7'd1;

    // copy argument gathering: lowest pending flag takes this byte
    always_comb begin
        low_bit = 3'd7;
        for (int i = 6; i >= 0; i--) begin
            if (r_flags[i]) begin
                low_bit = 3'(i);
            end
        end
    end
    assign lane_base = {low_bit[1:0], 3'b000};
    always_comb begin
        gath_off   = r_off;
        gath_len   = r_len;
        gath_flags = r_flags & ~(7'd1 << low_bit);
        if (low_bit < 3'd4) begin
            gath_off[lane_base +: 8] = r_off[lane_base +: 8] | i_delta_byte;
        end else if (low_bit < 3'd7) begin
            gath_len[lane_base +: 8] = r_len[lane_base +: 8] | i_delta_byte;
        end else begin
            gath_flags = 7'd0;
        end
    end

    // parse step
    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_grp     = r_grp;
        n_dts     = r_dts;
        n_tr      = r_tr;
        n_abr     = r_abr;
        n_flags   = r_flags;
        n_off     = r_off;
        n_len     = r_len;
        emit_lit  = 1'b0;
        emit_copy = 1'b0;
        fail_en   = 1'b0;
        fail_code = ERR_NONE;
        fin_en    = 1'b0;
        restart   = 1'b0;
        cd_en     = 1'b0;
        cd_off    = '0;
        cd_len    = '0;

        if (accept) begin
            case (r_phase)
                PH_HDR_BASE: begin
                    n_acc = take_acc;
                    n_grp = take_grp;
                    if (!i_delta_byte[7] || last) begin
                        n_acc = '0;
                        n_grp = '0;
                        if (hdr_size != base_diff[LENGTH_BITS-1:0]) begin
                            fail_en   = 1'b1;
                            fail_code = ERR_BASE_SIZE;
                        end else if (last) begin
                            n_dts  = '0;
                            n_tr   = '0;
                            fin_en = 1'b1;
                        end else begin
                            n_phase = PH_HDR_TGT;
                        end
                    end
                end
                PH_HDR_TGT: begin
                    n_acc = take_acc;
                    n_grp = take_grp;
                    if (!i_delta_byte[7] || last) begin
                        n_acc   = '0;
                        n_grp   = '0;
                        n_dts   = hdr_size;
                        n_tr    = hdr_size;
                        n_phase = PH_OPCODE;
                        fin_en  = last;
                    end
                end
                PH_OPCODE: begin
                    if (i_delta_byte == 8'd0) begin
                        fail_en   = 1'b1;
                        fail_code = ERR_OPCODE_ZERO;
                    end else if (!i_delta_byte[7]) begin
                        n_abr = i_delta_byte[6:0];
                        if (last) begin
                            fail_en   = 1'b1;
                            fail_code = ERR_ADD_TRUNC;
                        end else if (33'(i_delta_byte[6:0]) > tr_wide) begin
                            n_phase = PH_ADD_SKIP;
                        end else begin
                            n_phase = PH_ADD;
                        end
                    end else begin
                        n_flags = i_delta_byte[6:0];
                        n_off   = '0;
                        n_len   = '0;
                        if (i_delta_byte[6:0] == 7'd0) begin
                            cd_en = 1'b1;
                        end else if (last) begin
                            fail_en   = 1'b1;
                            fail_code = ERR_COPY_TRUNC;
                        end else begin
                            n_phase = PH_COPY;
                        end
                    end
                end
                PH_ADD: begin
                    emit_lit = 1'b1;
                    n_abr    = abr_dec;
                    n_tr     = r_tr - LENGTH_BITS'(1);
                    if (abr_dec == 7'd0) begin
                        n_phase = PH_OPCODE;
                        fin_en  = last;
                    end else if (last) begin
                        fail_en   = 1'b1;
                        fail_code = ERR_ADD_TRUNC;
                    end
                end
                PH_ADD_SKIP: begin
                    n_abr = abr_dec;
                    if (abr_dec == 7'd0) begin
                        fail_en   = 1'b1;
                        fail_code = ERR_ADD_OVER;
                    end else if (last) begin
                        fail_en   = 1'b1;
                        fail_code = ERR_ADD_TRUNC;
                    end
                end
                PH_COPY: begin
                    n_off   = gath_off;
                    n_len   = gath_len;
                    n_flags = gath_flags;
                    if (gath_flags == 7'd0) begin
                        cd_en  = 1'b1;
                        cd_off = gath_off;
                        cd_len = gath_len;
                    end else if (last) begin
                        fail_en   = 1'b1;
                        fail_code = ERR_COPY_TRUNC;
                    end
                end
                default: begin
                    // dropping the rest of a failed delta
                    restart = last;
                end
            endcase
        end

        // copy command checks: target room first, then base range
        cd_size      = (cd_len == 24'd0) ? 24'(COPY_MAX) : cd_len;
        cd_size_wide = 33'(cd_size);
        cd_too_big   = (cd_size_wide > tr_wide) || (cd_size > 24'(COPY_MAX));
        cd_beyond    = (33'(cd_off) + cd_size_wide) > 33'(r_base_length);
        if (cd_en) begin
            if (cd_too_big) begin
                fail_en   = 1'b1;
                fail_code = ERR_COPY_OVER;
            end else if (cd_beyond) begin
                fail_en   = 1'b1;
                fail_code = ERR_COPY_BEYOND;
            end else begin
                emit_copy = 1'b1;
                n_tr      = r_tr - cd_size_wide[LENGTH_BITS-1:0];
                n_off     = '0;
                n_len     = '0;
                n_phase   = PH_OPCODE;
                fin_en    = last;
            end
        end

        // results of this item
        prim  = emit_lit ? mk_lit(i_delta_byte) : mk_copy(cd_off, cd_size[16:0]);
        if (fail_en) begin
            trail = mk_err(fail_code);
        end else if (n_tr == '0) begin
            trail = mk_fin(32'(n_dts));
        end else begin
            trail = mk_err(ERR_UNDERFILL);
        end

        o_push.valid = accept && (emit_lit || emit_copy || fail_en || fin_en);
        if (emit_lit || emit_copy) begin
            o_push.pair.first  = prim;
            o_push.pair.second = trail;
            o_push.pair.two    = fail_en || fin_en;
        end else begin
            o_push.pair.first  = trail;
            o_push.pair.second = trail;
            o_push.pair.two    = 1'b0;
        end

        // end of delta or error: start over or drop
        if (fail_en && !last) begin
            n_phase = PH_DROP;
        end
        if (accept && last && (fail_en || fin_en)) begin
            restart = 1'b1;
        end
        if (restart) begin
            n_phase = PH_HDR_BASE;
            n_acc   = '0;
            n_grp   = '0;
            n_dts   = '0;
            n_tr    = '0;
            n_abr   = '0;
            n_flags = '0;
            n_off   = '0;
            n_len   = '0;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR_BASE;
            r_acc   <= '0;
            r_grp   <= '0;
            r_dts   <= '0;
            r_tr    <= '0;
            r_abr   <= '0;
            r_flags <= '0;
            r_off   <= '0;
            r_len   <= '0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_grp   <= n_grp;
            r_dts   <= n_dts;
            r_tr    <= n_tr;
            r_abr   <= n_abr;
            r_flags <= n_flags;
            r_off   <= n_off;
            r_len   <= n_len;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_length   <= '0;
            r_base_position <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE_LENGTH:   r_base_length   <= i_cfg_data;
                CFG_BASE_POSITION: r_base_position <= i_cfg_data;
                default:           r_base_length   <= r_base_length;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hdl/gdid_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gdid_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire gdid_pkg::t_push i_push,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_nonempty,
    output gdid_pkg::t_pair      o_head
);
    import gdid_pkg::*;

    t_pair               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count, n_count;

    assign o_full     = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];

    // occupancy
    always_comb begin
        case ({i_push.valid, i_pop})
            2'b10:   n_count = r_count + QUEUE_CW'(1);
            2'b01:   n_count = r_count - QUEUE_CW'(1);
            default: n_count = r_count;
        endcase
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.pair;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/gdid_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gdid_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_nonempty,
    input  wire gdid_pkg::t_pair i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output gdid_pkg::t_result    o_result
);
    import gdid_pkg::*;

    logic    r_out_valid, r_second_valid;
    t_result r_out, r_second;
    logic    out_taken, load, advance;

    assign out_taken = r_out_valid && i_ready;
    assign advance   = out_taken && r_second_valid;
    assign load      = !r_second_valid && (!r_out_valid || i_ready) && i_nonempty;
    assign o_pop     = load;
    assign o_valid   = r_out_valid;
    assign o_result  = r_out;

    // output stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_second_valid <= 1'b0;
        end else if (advance) begin
            r_second_valid <= 1'b0;
        end else if (load) begin
            r_out_valid    <= 1'b1;
            r_second_valid <= i_head.two;
        end else if (out_taken) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload, second result waits behind the first
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= r_second;
        end else if (load) begin
            r_out    <= i_head.first;
            r_second <= i_head.second;
        end
    end

endmodule

`default_nettype wire
